FILE: sv/chb_pkg.sv
// chb_pkg: shared constants, codes and types of the cumulative histogram binner
// no dependencies; imported by every module of the block
`default_nettype none

package chb_pkg;

    // sizing
    localparam int BOUND_COUNT     = 7;
    localparam int COUNTER_WIDTH   = 32;
    localparam int REG_BOUNDS      = 7;
    localparam int NBUCKETS        = BOUND_COUNT + 1;
    localparam int CNT_IDX_WIDTH   = (NBUCKETS > 1) ? $clog2(NBUCKETS) : 1;
    localparam int STEP_WIDTH      = $clog2(BOUND_COUNT + 3);
    localparam int VALUE_WIDTH     = 32;
    localparam int SUM_WIDTH       = 64;
    localparam int ITEM_WIDTH      = 64;
    localparam int IDX_WIDTH       = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);

    // request codes
    localparam logic OP_OBSERVE  = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_BUCKET = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_SUM    = 2'd2;

    // register index of the bounds-in-use count
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOUNDS_IN_USE = 3'd7;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    typedef logic [REG_BOUNDS-1:0][VALUE_WIDTH-1:0] t_bounds;

    // classified request travelling from front to back
    typedef struct packed {
        logic                   op;
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_WIDTH-1:0]   bucket;
    } t_item;

    // clamp the bounds-in-use register to the bounds present
    function automatic logic [IDX_WIDTH-1:0] active_bounds(input logic [IDX_WIDTH-1:0] b);
        logic [IDX_WIDTH-1:0] lim;
        lim = IDX_WIDTH'(BOUND_COUNT);
        return (b > lim) ? lim : b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/chb_front.sv
// chb_front: accepts requests, drops nan samples and finds the bucket of each sample
// depends on chb_pkg
`default_nettype none

module chb_front
    import chb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic                   i_op,
    input  wire logic                   i_nan,
    input  wire t_bounds                i_bounds,
    input  wire logic [IDX_WIDTH-1:0]   i_bounds_in_use,
    output logic                        o_q_valid,
    input  wire logic                   i_q_ready,
    output t_item                       o_q_item
);

    logic                 r_valid;
    t_item                r_item;
    logic                 w_accept;
    logic                 w_keep;
    logic [IDX_WIDTH-1:0] w_n;
    logic [IDX_WIDTH-1:0] w_bucket;
    logic                 w_found;

    assign o_s_tready = !r_valid || i_q_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_keep     = (i_op == OP_SNAPSHOT) || !i_nan;
    assign w_n        = active_bounds(i_bounds_in_use);

    // parallel compares, first hit in register order wins, else +inf bucket
    always_comb begin
        w_bucket = w_n;
        w_found  = 1'b0;
        for (int i = 0; i < BOUND_COUNT; i++) begin
            if (!w_found && (IDX_WIDTH'(i) < w_n) &&
                ($signed(i_value) <= $signed(i_bounds[i]))) begin
                w_bucket = IDX_WIDTH'(i);
                w_found  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept && w_keep) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_item.op     <= i_op;
            r_item.value  <= i_value;
            r_item.bucket <= w_bucket;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

endmodule

`default_nettype wire

FILE: sv/chb_queue.sv
// chb_queue: short first-in first-out queue of classified requests
// depends on chb_pkg
`default_nettype none

module chb_queue
    import chb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_item i_push_item,
    output logic       o_pop_valid,
    input  wire logic  i_pop,
    output t_item      o_pop_item
);

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr;
    logic [QPTR_WIDTH:0]   r_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_push_ready = (r_count != (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/chb_back.sv
// chb_back: updates the saturating counters and sum, and streams snapshots out
// depends on chb_pkg
`default_nettype none

module chb_back
    import chb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire t_item                i_q_item,
    output logic                      o_q_pop,
    input  wire logic [IDX_WIDTH-1:0] i_bounds_in_use,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [1:0]                o_kind,
    output logic [IDX_WIDTH-1:0]      o_index,
    output logic [ITEM_WIDTH-1:0]     o_value,
    output logic                      o_last
);

    logic [COUNTER_WIDTH-1:0] r_counts [NBUCKETS];
    logic [COUNTER_WIDTH-1:0] r_total;
    logic [SUM_WIDTH-1:0]     r_sum;
    logic [STEP_WIDTH-1:0]    r_step;
    logic                     r_out_valid;
    logic [1:0]               r_kind;
    logic [IDX_WIDTH-1:0]     r_index;
    logic [ITEM_WIDTH-1:0]    r_value;
    logic                     r_last;

    logic                     w_out_free;
    logic                     w_obs;
    logic                     w_snap;
    logic                     w_snap_end;
    logic [STEP_WIDTH-1:0]    w_n;
    logic [SUM_WIDTH:0]       w_sum_ext;
    logic [SUM_WIDTH-1:0]     n_sum;
    logic [1:0]               w_kind;
    logic [IDX_WIDTH-1:0]     w_index;
    logic [ITEM_WIDTH-1:0]    w_value;

    assign w_n        = STEP_WIDTH'(active_bounds(i_bounds_in_use));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_obs      = i_q_valid && (i_q_item.op == OP_OBSERVE);
    assign w_snap     = i_q_valid && (i_q_item.op == OP_SNAPSHOT) && w_out_free;
    assign w_snap_end = w_snap && (r_step == w_n + STEP_WIDTH'(2));
    assign o_q_pop    = w_obs || w_snap_end;

    // saturating add of the sign-extended sample
    always_comb begin
        w_sum_ext = {r_sum[SUM_WIDTH-1], r_sum} +
                    {{(SUM_WIDTH+1-VALUE_WIDTH){i_q_item.value[VALUE_WIDTH-1]}},
                     i_q_item.value};
        if (w_sum_ext[SUM_WIDTH] != w_sum_ext[SUM_WIDTH-1]) begin
            n_sum = w_sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = w_sum_ext[SUM_WIDTH-1:0];
        end
    end

    // snapshot sequence: buckets, then total count, then sum
    always_comb begin
        if (r_step <= w_n) begin
            w_kind  = KIND_BUCKET;
            w_index = IDX_WIDTH'(r_step);
            w_value = ITEM_WIDTH'(r_counts[r_step[CNT_IDX_WIDTH-1:0]]);
        end else if (r_step == w_n + STEP_WIDTH'(1)) begin
            w_kind  = KIND_COUNT;
            w_index = '0;
            w_value = ITEM_WIDTH'(r_total);
        end else begin
            w_kind  = KIND_SUM;
            w_index = '0;
            w_value = ITEM_WIDTH'(r_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NBUCKETS; j++) begin
                r_counts[j] <= '0;
            end
            r_total     <= '0;
            r_sum       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_obs) begin
                r_sum <= n_sum;
                if (r_total != CNT_MAX) begin
                    r_total <= r_total + 1'b1;
                end
                // cumulative: the hit bucket and every later one in use
                for (int j = 0; j < NBUCKETS; j++) begin
                    if ((STEP_WIDTH'(j) >= STEP_WIDTH'(i_q_item.bucket)) &&
                        (STEP_WIDTH'(j) <= w_n) && (r_counts[j] != CNT_MAX)) begin
                        r_counts[j] <= r_counts[j] + 1'b1;
                    end
                end
            end
            if (w_snap_end) begin
                r_step <= '0;
            end else if (w_snap) begin
                r_step <= r_step + 1'b1;
            end
            if (w_out_free) begin
                r_out_valid <= w_snap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap) begin
            r_kind  <= w_kind;
            r_index <= w_index;
            r_value <= w_value;
            r_last  <= w_snap_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_kind     = r_kind;
    assign o_index    = r_index;
    assign o_value    = r_value;
    assign o_last     = r_last;

endmodule

`default_nettype wire

FILE: sv/cumulative_histogram_binner.sv
// cumulative_histogram_binner: top level, configuration registers and wiring
// depends on chb_pkg, chb_front, chb_queue and chb_back
//
// usage
//   slave stream carries requests: tuser[0] op (0 observe, 1 snapshot),
//   tuser[1] nan flag, tdata the signed q16.16 sample
//   master stream carries results: tuser the kind (bucket, count, sum),
//   tdata bucket index and 64-bit value, tlast on the sum closing a snapshot
//   the write port loads bounds 0..6 at indexes 0..6 and bounds in use at 7
// timing
//   observe requests are taken one per cycle while the queue has room and give
//   no result; the bucket compares all run in parallel in the front stage
//   a snapshot passes through the front register, the queue and the output
//   register, then gives bounds-in-use + 3 results, one result per cycle
//   while the receiver keeps tready high
//   a four-entry queue separates classification from counter update, so the
//   front keeps taking requests while a snapshot drains
// reset
//   synchronous, active low: counters, sum, bounds and queue all cleared
// stall
//   a low tready holds the output register; a snapshot in the back end then
//   stops, the queue fills and the slave tready drops once it and the front are full
`default_nettype none

module cumulative_histogram_binner
    import chb_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write port
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  i_cfg_wdata,
    // request stream
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [31:0]                i_s_tdata,   // [31:0] sample_value
    input  wire logic [1:0]                 i_s_tuser,   // [0] op, [1] sample_is_nan
    // result stream
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [71:0]                     o_m_tdata,   // [2:0] bucket_index, [66:3] item_value
    output logic [1:0]                      o_m_tuser,   // [1:0] item_kind
    output logic                            o_m_tlast
);

    // configuration registers
    t_bounds              r_bounds;
    logic [IDX_WIDTH-1:0] r_bounds_in_use;

    // front to queue
    logic  w_fe_valid;
    logic  w_q_ready;
    t_item w_fe_item;

    // queue to back
    logic  w_q_valid;
    logic  w_q_pop;
    t_item w_q_item;

    logic [IDX_WIDTH-1:0]  w_index;
    logic [ITEM_WIDTH-1:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds        <= '0;
            r_bounds_in_use <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_BOUNDS_IN_USE) begin
                r_bounds_in_use <= i_cfg_wdata[IDX_WIDTH-1:0];
            end else begin
                r_bounds[i_cfg_index] <= i_cfg_wdata[VALUE_WIDTH-1:0];
            end
        end
    end

    chb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .o_s_tready      (o_s_tready),
        .i_value         (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_op            (i_s_tuser[0]),
        .i_nan           (i_s_tuser[1]),
        .i_bounds        (r_bounds),
        .i_bounds_in_use (r_bounds_in_use),
        .o_q_valid       (w_fe_valid),
        .i_q_ready       (w_q_ready),
        .o_q_item        (w_fe_item)
    );

    chb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fe_valid),
        .o_push_ready (w_q_ready),
        .i_push_item  (w_fe_item),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_item   (w_q_item)
    );

    chb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .i_bounds_in_use (r_bounds_in_use),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_kind          (o_m_tuser),
        .o_index         (w_index),
        .o_value         (w_value),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {5'b0, w_value, w_index};

    // a snapshot always closes on the sum
    a_last_is_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == KIND_SUM)
        else $error("last flag on a result that is not the sum");

    // count and sum results carry bucket index zero
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_COUNT || o_m_tuser == KIND_SUM)
        |-> o_m_tdata[2:0] == 3'd0)
        else $error("non-zero bucket index on a count or sum result");

    // a classified request is never dropped while the queue is full
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fe_valid && !w_q_ready |=> w_fe_valid && $stable(w_fe_item))
        else $error("front stage lost a request while the queue was full");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking bench for cumulative_histogram_binner, predicts every snapshot result
// depends on chb_pkg and cumulative_histogram_binner; reads no files, needs no arguments
`timescale 1ns / 100ps

module tb;
    import chb_pkg::*;

    localparam int SETTLE_CYCLES = 20;       // snapshot latency plus queue and front stages
    localparam int CYCLE_LIMIT   = 400000;   // far above the slowest legal run
    localparam int PHASE_ITEMS   = 62;       // random requests per idling phase

    // one expected result as seen on the master stream
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [63:0] value;
        logic        last;
    } t_result;

    // stimulus side, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [31:0] cfg_wdata   = '0;
    logic        s_tvalid    = 1'b0;
    logic [31:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tready    = 1'b0;

    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [71:0] o_m_tdata;
    wire  [1:0]  o_m_tuser;
    wire         o_m_tlast;

    // idling percentages of the current phase
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int cycle_count = 0;
    int mismatches  = 0;

    // histogram predictor: its own copy of registers and counters
    logic signed [31:0]        hist_bounds [REG_BOUNDS];
    logic [2:0]                hist_in_use;
    logic [COUNTER_WIDTH-1:0]  hist_buckets [NBUCKETS];
    logic [COUNTER_WIDTH-1:0]  hist_total;
    logic signed [63:0]        hist_sum;

    // results still owed by the block, oldest first
    t_result expected_results [$];

    // bound set to be loaded by the next programming pass
    logic signed [31:0] plan_bounds [REG_BOUNDS];

    cumulative_histogram_binner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),     // [31:0] sample_value
        .i_s_tuser   (s_tuser),     // [0] op, [1] sample_is_nan
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),   // [2:0] bucket_index, [66:3] item_value
        .o_m_tuser   (o_m_tuser),   // [1:0] item_kind
        .o_m_tlast   (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle away from the sampling edge
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic int live_bounds();
        return (int'(hist_in_use) > BOUND_COUNT) ? BOUND_COUNT : int'(hist_in_use);
    endfunction

    // counters stick at all ones
    function automatic logic [COUNTER_WIDTH-1:0] bump(input logic [COUNTER_WIDTH-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    task automatic clear_histogram();
        for (int i = 0; i < REG_BOUNDS; i++) hist_bounds[i] = '0;
        for (int i = 0; i < NBUCKETS; i++) hist_buckets[i] = '0;
        hist_in_use = '0;
        hist_total  = '0;
        hist_sum    = '0;
    endtask

    task automatic apply_register(input logic [2:0] index, input logic [31:0] value);
        if (int'(index) < REG_BOUNDS)
            hist_bounds[index] = value;
        else if (index == CFG_BOUNDS_IN_USE)
            hist_in_use = value[2:0];
    endtask

    // count one sample: total, clamped sum, and the cumulative run of buckets
    task automatic bin_sample(input logic [31:0] raw);
        logic signed [31:0] v;
        logic signed [64:0] wide;
        int n;
        int first;
        v = raw;
        n = live_bounds();
        hist_total = bump(hist_total);
        wide = {hist_sum[63], hist_sum} + {{33{v[31]}}, v};
        if (wide[64] != wide[63])
            hist_sum = wide[64] ? SUM_MIN : SUM_MAX;
        else
            hist_sum = wide[63:0];
        // first bound in register order that holds the sample, else +inf
        first = n;
        for (int i = n - 1; i >= 0; i--)
            if (v <= hist_bounds[i]) first = i;
        for (int j = first; j <= n; j++)
            hist_buckets[j] = bump(hist_buckets[j]);
    endtask

    // append one result to the tail of the owed list
    task automatic owe_result(input t_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    // queue up every bucket, then the count, then the sum closing the frame
    task automatic expect_snapshot();
        t_result r;
        int n;
        n = live_bounds();
        for (int i = 0; i <= n; i++) begin
            r.kind  = KIND_BUCKET;
            r.idx   = i[2:0];
            r.value = 64'(hist_buckets[i]);
            r.last  = 1'b0;
            owe_result(r);
        end
        r.kind  = KIND_COUNT;
        r.idx   = '0;
        r.value = 64'(hist_total);
        r.last  = 1'b0;
        owe_result(r);
        r.kind  = KIND_SUM;
        r.value = hist_sum;
        r.last  = 1'b1;
        owe_result(r);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // every accepted result is held against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d idx %0d value %h",
                                          o_m_tuser, o_m_tdata[2:0], o_m_tdata[66:3]));
            end else begin
                t_result want;
                want = expected_results.pop_front();
                if (o_m_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d", o_m_tuser, want.kind));
                if (o_m_tdata[2:0] !== want.idx)
                    report_mismatch($sformatf("bucket index %0d, wanted %0d",
                                              o_m_tdata[2:0], want.idx));
                if (o_m_tdata[66:3] !== want.value)
                    report_mismatch($sformatf("value %h, wanted %h (kind %0d idx %0d)",
                                              o_m_tdata[66:3], want.value, want.kind, want.idx));
                if (o_m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, wanted %b (kind %0d idx %0d)",
                                              o_m_tlast, want.last, want.kind, want.idx));
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // entered just after a falling edge; returns just after the falling edge
    // that follows acceptance, having left tvalid as it was
    task automatic send_request(input logic op, input logic [31:0] value, input logic nan);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {nan, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // accepted at this edge: fold it into the prediction
        if (op == OP_SNAPSHOT)
            expect_snapshot();
        else if (!nan)
            bin_sample(value);
        @(negedge i_clk);
    endtask

    // stop sending, let every owed result arrive and the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_register(input logic [2:0] index, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge i_clk);
        apply_register(index, value);
        @(negedge i_clk);
    endtask

    // writes every bound from the plan, then the bounds-in-use count
    task automatic program_bounds(input int in_use);
        for (int i = 0; i < REG_BOUNDS; i++)
            load_register(i[2:0], plan_bounds[i]);
        load_register(CFG_BOUNDS_IN_USE, 32'(in_use));
        cfg_wr_en <= 1'b0;
    endtask

    // bound sets of several shapes: sorted, scattered, clustered, extreme
    task automatic draw_bounds(input int style);
        logic signed [31:0] t;
        for (int i = 0; i < REG_BOUNDS; i++) begin
            case (style)
                0, 1:    plan_bounds[i] = $urandom();
                2:       plan_bounds[i] = 32'($urandom_range(6)) * 32'h0001_0000
                                          - 32'h0003_0000;
                default: plan_bounds[i] = $urandom_range(1) ? 32'h7fff_ffff
                                          : 32'h8000_0000 + 32'($urandom_range(3));
            endcase
        end
        if (style == 0 || style == 2) begin
            for (int i = 1; i < REG_BOUNDS; i++)
                for (int j = i; j > 0; j--)
                    if (plan_bounds[j] < plan_bounds[j-1]) begin
                        t = plan_bounds[j];
                        plan_bounds[j] = plan_bounds[j-1];
                        plan_bounds[j-1] = t;
                    end
        end
    endtask

    // samples aimed at bounds and extremes as well as spread at random
    function automatic logic [31:0] pick_sample();
        logic [31:0] s;
        case ($urandom_range(9))
            0, 1, 2: s = $urandom();
            3, 4, 5: s = hist_bounds[$urandom_range(REG_BOUNDS - 1)]
                         + 32'($urandom_range(2)) - 32'd1;
            6:       s = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: s = 32'($urandom_range(400000)) - 32'd200000;
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------- tests

    // snapshot of the cleared block, then one sample into the lone +inf bucket
    task automatic test_reset_snapshot();
        send_request(OP_SNAPSHOT, 32'h0, 1'b0);
        send_request(OP_OBSERVE, 32'h1234_5678, 1'b0);
        send_request(OP_SNAPSHOT, 32'hffff_ffff, 1'b0);
    endtask

    // unsorted bounds with duplicates and both extremes, all seven in use
    task automatic test_directed_bins();
        wait_idle();
        plan_bounds[0] = 32'h8000_0000;
        plan_bounds[1] = 32'h0001_0000;     // +1.0, ahead of smaller bounds
        plan_bounds[2] = 32'hffff_0000;     // -1.0
        plan_bounds[3] = 32'h0000_0000;
        plan_bounds[4] = 32'h0000_0000;     // duplicate, never first
        plan_bounds[5] = 32'h7fff_fffe;
        plan_bounds[6] = 32'h7fff_ffff;
        program_bounds(BOUND_COUNT);
        send_request(OP_OBSERVE, 32'h8000_0000, 1'b0);   // equal to the lowest bound
        send_request(OP_OBSERVE, 32'h8000_0001, 1'b0);
        send_request(OP_OBSERVE, 32'h0001_0000, 1'b0);
        send_request(OP_OBSERVE, 32'h0001_0001, 1'b0);
        send_request(OP_OBSERVE, 32'hffff_0000, 1'b0);   // caught early by unsorted bound
        send_request(OP_OBSERVE, 32'h7fff_fffe, 1'b0);
        send_request(OP_OBSERVE, 32'h7fff_ffff, 1'b0);   // highest finite bucket by equality
        send_request(OP_OBSERVE, 32'h0000_0000, 1'b0);
        send_request(OP_OBSERVE, 32'hffff_ffff, 1'b1);   // nan: must leave no trace
        send_request(OP_OBSERVE, 32'h0000_0000, 1'b1);
        send_request(OP_SNAPSHOT, 32'h5555_aaaa, 1'b1);  // nan flag is ignored here
    endtask

    // fewer bounds in use keeps the counters; large samples land in +inf
    task automatic test_bounds_shrink();
        wait_idle();
        program_bounds(2);
        send_request(OP_OBSERVE, 32'h7fff_ffff, 1'b0);
        send_request(OP_OBSERVE, 32'h8000_0000, 1'b0);
        send_request(OP_OBSERVE, 32'hffff_ffff, 1'b0);
        send_request(OP_SNAPSHOT, 32'h0, 1'b0);
    endtask

    // one idling phase of random traffic under a fresh bound set
    task automatic test_random_traffic(input int phase, input int src_pct, input int snk_pct);
        int in_use;
        logic op;
        logic nan;
        wait_idle();
        draw_bounds(phase);
        case (phase)
            0:       in_use = BOUND_COUNT;
            1:       in_use = $urandom_range(1, BOUND_COUNT - 1);
            2:       in_use = $urandom_range(0, BOUND_COUNT);
            default: in_use = 0;
        endcase
        program_bounds(in_use);
        sender_idle_pct    = src_pct;
        receiver_stall_pct = snk_pct;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            op  = ($urandom_range(99) < 12) ? OP_SNAPSHOT : OP_OBSERVE;
            nan = ($urandom_range(99) < 8);
            send_request(op, pick_sample(), nan);
        end
        // close every phase with a readout of what it built up
        send_request(OP_SNAPSHOT, $urandom(), 1'($urandom_range(1)));
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_histogram();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_snapshot();
        test_directed_bins();
        test_bounds_shrink();
        test_random_traffic(0, 0, 0);
        test_random_traffic(1, 60, 0);
        test_random_traffic(2, 0, 60);
        test_random_traffic(3, 20, 20);

        wait_idle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
